>>> src/x86_prologue_byte_scanner_core_assert.svh
// Assertion macros used by the checker of the prologue scanner.
`ifndef X86_PROLOGUE_BYTE_SCANNER_CORE_ASSERT_SVH
`define X86_PROLOGUE_BYTE_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication: when pre holds, post must hold too.
`define XPBS_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("prologue scanner check failed");

// Next-cycle implication: when pre holds, post must hold in the next cycle.
`define XPBS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("prologue scanner check failed");

`endif

>>> src/xpbs_pkg.sv
// ----------------------------------------------------------------------------
// xpbs_pkg
// Types and constants of the x86 prologue byte scanner.
// ----------------------------------------------------------------------------
package xpbs_pkg;

   localparam int OFFSET_WIDTH_DEFAULT = 32;
   localparam int COUNT_WIDTH_DEFAULT  = 16;

   // Byte cells in the window: data[i-2] .. data[i+4].
   localparam int WIN_CELLS  = 7;
   localparam int WIN_LEAD   = 4;   // bytes ahead of the tested position
   localparam int PAD_LAG    = 2;   // bytes behind needed by the padding rule
   localparam int MIN_BUFFER = 16;
   localparam int SKIP_COUNT = 8;

   localparam logic [15:0] LIMIT_RESET = 16'd4096;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      REG_MODE   = 2'd0,
      REG_BASE   = 2'd1,
      REG_LENGTH = 2'd2,
      REG_LIMIT  = 2'd3
   } csr_index_type;

   // Opcode and padding bytes
   localparam logic [7:0] OPC_REX_W     = 8'h48;
   localparam logic [7:0] OPC_GRP1_IMM8 = 8'h83;
   localparam logic [7:0] MODRM_ESP     = 8'hEC;
   localparam logic [7:0] OPC_PUSH_EBP  = 8'h55;
   localparam logic [7:0] OPC_MOV_RM    = 8'h8B;
   localparam logic [7:0] PFX_REP       = 8'hF3;
   localparam logic [7:0] OPC_ESCAPE    = 8'h0F;
   localparam logic [7:0] OPC_ENDBR     = 8'h1E;
   localparam logic [7:0] PAD_INT3      = 8'hCC;
   localparam logic [7:0] OPC_RET       = 8'hC3;
   localparam logic [7:0] PAD_NOP       = 8'h90;

   typedef logic [WIN_CELLS-1:0][7:0] window_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic mode_64bit;
      logic pad_ok;    // tested position is at offset two or later
      logic tail_ok;   // one more byte beyond the window lies in the buffer
   } match_ctrl_type;

endpackage

>>> src/xpbs_byte_cell.sv
// ----------------------------------------------------------------------------
// xpbs_byte_cell
// One byte cell of the scan window; on each request it takes its input byte, or zero when cleared.
// ----------------------------------------------------------------------------
module xpbs_byte_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  xpbs_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             d_in,
   output logic [7:0]             q,
   output logic [7:0]             q_next
);
   import xpbs_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.shift) begin
         byte_in = ctrl.clear ? 8'h00 : d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign q      = byte_ff;
   assign q_next = byte_in;

endmodule

>>> src/xpbs_match.sv
// ----------------------------------------------------------------------------
// xpbs_match
// Prologue pattern and padding-transition match over the window cells.
// ----------------------------------------------------------------------------
module xpbs_match (
   input  xpbs_pkg::window_type     win,
   input  xpbs_pkg::match_ctrl_type ctrl,
   output logic                     hit
);
   import xpbs_pkg::*;

   logic [7:0] wm2, wm1, w0, w1, w2, w3, w4;
   logic       hit64, hit32, hit_pad;

   always_comb begin
      wm2 = win[0];
      wm1 = win[1];
      w0  = win[2];
      w1  = win[3];
      w2  = win[4];
      w3  = win[5];
      w4  = win[6];

      hit64 = 1'b0;
      if (w0 == OPC_REX_W && w1 == 8'h89 && w2 == 8'h5C && w3 == 8'h24) hit64 = 1'b1;
      if (w0 == OPC_REX_W && w1 == OPC_GRP1_IMM8 && w2 == MODRM_ESP && w3 >= 8'h08)
         hit64 = 1'b1;
      if (w0 == OPC_REX_W && w1 == 8'h81 && w2 == MODRM_ESP) hit64 = 1'b1;
      if (w0 == OPC_PUSH_EBP && w1 == OPC_REX_W && w2 == OPC_MOV_RM && w3 == MODRM_ESP)
         hit64 = 1'b1;
      if (w0 == 8'h4C && w1 == 8'h89 && (w2 == 8'h44 || w2 == 8'h4C) && w3 == 8'h24)
         hit64 = 1'b1;
      if (w0 == PFX_REP && w1 == OPC_ESCAPE && w2 == OPC_ENDBR && w3 == 8'hFA)
         hit64 = 1'b1;
      if (w0 == 8'h40 && w1 >= 8'h50 && w1 <= 8'h57 && w2 == OPC_REX_W &&
          w3 == OPC_GRP1_IMM8 && w4 == MODRM_ESP) hit64 = 1'b1;
      if ((w0 == 8'h53 || w0 == 8'h56 || w0 == 8'h57) && w1 == OPC_REX_W &&
          w2 == OPC_GRP1_IMM8 && w3 == MODRM_ESP) hit64 = 1'b1;
      if (w0 == OPC_REX_W && w1 == OPC_MOV_RM && w2 == 8'hC4) hit64 = 1'b1;

      hit32 = 1'b0;
      if (w0 == OPC_PUSH_EBP && w1 == OPC_MOV_RM && w2 == MODRM_ESP) hit32 = 1'b1;
      if (w0 == OPC_GRP1_IMM8 && w1 == MODRM_ESP && w2 >= 8'h08) hit32 = 1'b1;
      if (w0 == 8'h81 && w1 == MODRM_ESP) hit32 = 1'b1;
      if (w0 == PFX_REP && w1 == OPC_ESCAPE && w2 == OPC_ENDBR && w3 == 8'hFB)
         hit32 = 1'b1;
      // hot-patch prologue reaches one byte past the window
      if (ctrl.tail_ok && w0 == OPC_MOV_RM && w1 == 8'hFF && w2 == OPC_PUSH_EBP &&
          w3 == OPC_MOV_RM && w4 == MODRM_ESP) hit32 = 1'b1;

      hit_pad = 1'b0;
      if (ctrl.pad_ok && w0 != PAD_INT3 && w0 != PAD_NOP && w0 != 8'h00) begin
         if (wm1 == PAD_INT3 && wm2 == PAD_INT3) hit_pad = 1'b1;
         if (wm1 == OPC_RET && (wm2 == PAD_INT3 || wm2 == PAD_NOP)) hit_pad = 1'b1;
      end

      hit = (ctrl.mode_64bit ? hit64 : hit32) | hit_pad;
   end

endmodule

>>> src/x86_prologue_byte_scanner_core.sv
// ----------------------------------------------------------------------------
// x86_prologue_byte_scanner_core
// Scans a code byte stream for x86 function prologues and padding ends.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  req_     | in  | tvalid / tready    | tdata: code_byte, tuser: buffer_start
//  rsp_     | out | tvalid / tready    | tdata: candidate_address, candidate_number
//  csr_     | in  | APB psel / penable | 64-bit registers at byte address 8*i
//
//  One request per clock; a hit is registered and shown the cycle after its
//  request. The window is a row of seven byte cells shifting once per request.
//  req_tready drops only while a result is held and rsp_tready is low.
//  Reset is synchronous and restores registers and scan state; no clearing pass.
// ----------------------------------------------------------------------------
module x86_prologue_byte_scanner_core #(
   parameter int OFFSET_WIDTH = xpbs_pkg::OFFSET_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = xpbs_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] code_byte
   input  logic [0:0]  req_tuser,    // [0] buffer_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,    // [63:0] candidate_address, [79:64] candidate_number
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import xpbs_pkg::*;

   localparam int LW = (OFFSET_WIDTH > 32 ? OFFSET_WIDTH : 32) + 1;
   localparam int CW = (COUNT_WIDTH > 16 ? COUNT_WIDTH : 16) + 1;

   // Configuration registers
   logic        mode_ff;
   logic [63:0] base_ff;
   logic [31:0] length_ff;
   logic [15:0] limit_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b1;
         base_ff   <= 64'd0;
         length_ff <= 32'd0;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[4:3])
            REG_MODE:   mode_ff   <= csr_pwdata[0];
            REG_BASE:   base_ff   <= csr_pwdata;
            REG_LENGTH: length_ff <= csr_pwdata[31:0];
            REG_LIMIT:  limit_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         REG_MODE:   csr_prdata = {63'd0, mode_ff};
         REG_BASE:   csr_prdata = base_ff;
         REG_LENGTH: csr_prdata = {32'd0, length_ff};
         REG_LIMIT:  csr_prdata = {48'd0, limit_ff};
         default:    csr_prdata = 64'd0;
      endcase
   end

   // Handshake
   logic rsp_valid_ff;
   logic accept;
   logic start;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign start      = req_tuser[0];

   // Window cells: cell k holds data[i-2+k]
   window_type    cell_q, cell_next, cell_d;
   cell_ctrl_type cell_ctrl [WIN_CELLS];

   for (genvar k = 0; k < WIN_CELLS; k++) begin : g_cell
      if (k == WIN_CELLS - 1) begin : g_head
         assign cell_d[k]          = req_tdata;
         assign cell_ctrl[k].clear = 1'b0;
      end else begin : g_body
         assign cell_d[k]          = cell_q[k+1];
         assign cell_ctrl[k].clear = start;
      end
      assign cell_ctrl[k].shift = accept;

      xpbs_byte_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (cell_ctrl[k]),
         .d_in   (cell_d[k]),
         .q      (cell_q[k]),
         .q_next (cell_next[k])
      );
   end

   // Scan state
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in, pos_cur, pos_i;
   logic [3:0]              skip_ff, skip_in, skip_cur;
   logic [COUNT_WIDTH-1:0]  cnt_ff, cnt_in, cnt_cur;
   logic [LW-1:0]           pos_ext, pos_ext1, len_ext;
   logic                    sat, test, hit, emit;
   logic [64:0]             addr_sum;
   logic [CW-1:0]           cnt_ext, limit_ext, num_ext;
   match_ctrl_type          mctrl;

   always_comb begin
      pos_cur  = start ? '0 : pos_ff;
      skip_cur = start ? 4'd0 : skip_ff;
      cnt_cur  = start ? '0 : cnt_ff;

      sat      = &pos_cur;
      pos_ext  = {{(LW-OFFSET_WIDTH){1'b0}}, pos_cur};
      pos_ext1 = pos_ext + LW'(1);
      len_ext  = {{(LW-32){1'b0}}, length_ff};
      cnt_ext   = {{(CW-COUNT_WIDTH){1'b0}}, cnt_cur};
      limit_ext = {{(CW-16){1'b0}}, limit_ff};

      test = ~sat && (pos_ext >= LW'(WIN_LEAD)) && (pos_ext < len_ext) &&
             (length_ff >= 32'(MIN_BUFFER)) && (cnt_ext < limit_ext);

      pos_i = pos_cur - OFFSET_WIDTH'(WIN_LEAD);
      mctrl.mode_64bit = mode_ff;
      mctrl.pad_ok     = pos_ext >= LW'(WIN_LEAD + PAD_LAG);
      mctrl.tail_ok    = pos_ext1 < len_ext;
   end

   xpbs_match u_match (
      .win  (cell_next),
      .ctrl (mctrl),
      .hit  (hit)
   );

   always_comb begin
      addr_sum = {1'b0, base_ff} + {{(65-OFFSET_WIDTH){1'b0}}, pos_i};
      // drop a hit whose address wraps; its skip still applies
      emit     = test && (skip_cur == 4'd0) && hit && ~addr_sum[64];

      skip_in = skip_cur;
      if (test) begin
         if (skip_cur != 4'd0) begin
            skip_in = skip_cur - 4'd1;
         end else if (hit) begin
            skip_in = 4'(SKIP_COUNT);
         end
      end

      cnt_in  = emit ? cnt_cur + COUNT_WIDTH'(1) : cnt_cur;
      num_ext = {{(CW-COUNT_WIDTH){1'b0}}, cnt_in};
      pos_in  = sat ? pos_cur : pos_cur + OFFSET_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         skip_ff <= 4'd0;
         cnt_ff  <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         skip_ff <= skip_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Result register
   logic [63:0] addr_ff;
   logic [15:0] num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         addr_ff <= addr_sum[63:0];
         num_ff  <= num_ext[15:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {num_ff, addr_ff};

endmodule

>>> src/xpbs_checker.sv
// ----------------------------------------------------------------------------
// xpbs_checker
// Port-level checks of the prologue scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "x86_prologue_byte_scanner_core_assert.svh"

module xpbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [4:0]  csr_paddr,
   input logic [63:0] csr_pwdata,
   input logic [63:0] csr_prdata,
   input logic        csr_pready
);

   // Stalled result holds its payload
   `XPBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Input stalls only behind a blocked result
   `XPBS_ASSERT_NOW(a_skid, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)

   // First byte of a buffer never yields a result
   `XPBS_ASSERT_NEXT(a_start_quiet, clock, reset, req_tvalid && req_tready && req_tuser[0], !rsp_tvalid)

   // Reset leaves no result pending
   `XPBS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // Configuration port never waits
   `XPBS_ASSERT_NOW(a_pready, clock, 1'b0, 1'b1, csr_pready)

endmodule

bind x86_prologue_byte_scanner_core xpbs_checker u_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the x86 prologue byte scanner: streams code buffers with
// planted prologues, padding runs and near misses under several register
// settings, predicts every candidate address and checks each result.
// ----------------------------------------------------------------------------
package prologue_check_pkg;
   import xpbs_pkg::*;

   // Pattern bytes not named in the block's package
   localparam logic [7:0] OPC_MOV_STORE   = 8'h89;
   localparam logic [7:0] OPC_GRP1_IMM32  = 8'h81;
   localparam logic [7:0] OPC_REX         = 8'h40;
   localparam logic [7:0] OPC_REX_WR      = 8'h4C;
   localparam logic [7:0] OPC_PUSH_FIRST  = 8'h50;
   localparam logic [7:0] OPC_PUSH_RBX    = 8'h53;
   localparam logic [7:0] OPC_PUSH_RSI    = 8'h56;
   localparam logic [7:0] OPC_PUSH_LAST   = 8'h57;
   localparam logic [7:0] MODRM_RBX_SIB   = 8'h5C;
   localparam logic [7:0] MODRM_EAX_SIB   = 8'h44;
   localparam logic [7:0] MODRM_ECX_SIB   = 8'h4C;
   localparam logic [7:0] SIB_RSP         = 8'h24;
   localparam logic [7:0] MODRM_RAX_RSP   = 8'hC4;
   localparam logic [7:0] MODRM_EDI_EDI   = 8'hFF;
   localparam logic [7:0] ENDBR64_TAIL    = 8'hFA;
   localparam logic [7:0] ENDBR32_TAIL    = 8'hFB;
   localparam logic [7:0] PAD_ZERO        = 8'h00;
   localparam logic [7:0] FRAME_MIN       = 8'h08;

   typedef struct {
      logic [63:0] address;
      logic [15:0] number;
   } candidate_type;

   class prologue_tracker;
      bit            mode_64;
      bit [63:0]     base;
      bit [31:0]     length;
      bit [15:0]     limit;
      bit [7:0]      window [8];   // newest byte in the top cell
      bit [31:0]     position;
      bit [3:0]      skip;
      bit [15:0]     found;
      candidate_type awaited_candidates [$];
      int            errors;
      int            checked;
      int            bytes_seen;

      function new();
         mode_64 = 1'b1;
         base    = '0;
         length  = '0;
         limit   = LIMIT_RESET;
         clear_scan();
      endfunction

      function void clear_scan();
         foreach (window[k]) window[k] = '0;
         position = '0;
         skip     = '0;
         found    = '0;
      endfunction

      function void report(string text);
         errors++;
         $display("%0t: %s", $time, text);
      endfunction

      function void set_register(csr_index_type idx, logic [63:0] value);
         case (idx)
            REG_MODE:   mode_64 = value[0];
            REG_BASE:   base = value;
            REG_LENGTH: length = value[31:0];
            REG_LIMIT:  limit = value[15:0];
            default:    ;
         endcase
      endfunction

      // Tested byte sits in cell 3; two bytes behind it, four ahead.
      function bit opens_function(bit [31:0] i);
         bit [7:0] p2, p1, b0, b1, b2, b3, b4;
         p2 = window[1];
         p1 = window[2];
         b0 = window[3];
         b1 = window[4];
         b2 = window[5];
         b3 = window[6];
         b4 = window[7];
         if (mode_64) begin
            if (b0 == OPC_REX_W && b1 == OPC_MOV_STORE && b2 == MODRM_RBX_SIB && b3 == SIB_RSP)
               return 1'b1;
            if (b0 == OPC_REX_W && b1 == OPC_GRP1_IMM8 && b2 == MODRM_ESP && b3 >= FRAME_MIN)
               return 1'b1;
            if (b0 == OPC_REX_W && b1 == OPC_GRP1_IMM32 && b2 == MODRM_ESP)
               return 1'b1;
            if (b0 == OPC_PUSH_EBP && b1 == OPC_REX_W && b2 == OPC_MOV_RM && b3 == MODRM_ESP)
               return 1'b1;
            if (b0 == OPC_REX_WR && b1 == OPC_MOV_STORE && b3 == SIB_RSP &&
                (b2 == MODRM_EAX_SIB || b2 == MODRM_ECX_SIB))
               return 1'b1;
            if (b0 == PFX_REP && b1 == OPC_ESCAPE && b2 == OPC_ENDBR && b3 == ENDBR64_TAIL)
               return 1'b1;
            if (b0 == OPC_REX && b1 >= OPC_PUSH_FIRST && b1 <= OPC_PUSH_LAST &&
                b2 == OPC_REX_W && b3 == OPC_GRP1_IMM8 && b4 == MODRM_ESP)
               return 1'b1;
            if ((b0 == OPC_PUSH_RBX || b0 == OPC_PUSH_RSI || b0 == OPC_PUSH_LAST) &&
                b1 == OPC_REX_W && b2 == OPC_GRP1_IMM8 && b3 == MODRM_ESP)
               return 1'b1;
            if (b0 == OPC_REX_W && b1 == OPC_MOV_RM && b2 == MODRM_RAX_RSP)
               return 1'b1;
         end else begin
            if (b0 == OPC_PUSH_EBP && b1 == OPC_MOV_RM && b2 == MODRM_ESP)
               return 1'b1;
            if (b0 == OPC_GRP1_IMM8 && b1 == MODRM_ESP && b2 >= FRAME_MIN)
               return 1'b1;
            if (b0 == OPC_GRP1_IMM32 && b1 == MODRM_ESP)
               return 1'b1;
            if (b0 == PFX_REP && b1 == OPC_ESCAPE && b2 == OPC_ENDBR && b3 == ENDBR32_TAIL)
               return 1'b1;
            // hot-patch form needs one byte beyond the window inside the buffer
            if ((64'(i) + 64'd5) < 64'(length) && b0 == OPC_MOV_RM && b1 == MODRM_EDI_EDI &&
                b2 == OPC_PUSH_EBP && b3 == OPC_MOV_RM && b4 == MODRM_ESP)
               return 1'b1;
         end
         if (i >= 2 && b0 != PAD_INT3 && b0 != PAD_NOP && b0 != PAD_ZERO) begin
            if (p1 == PAD_INT3 && p2 == PAD_INT3)
               return 1'b1;
            if (p1 == OPC_RET && (p2 == PAD_INT3 || p2 == PAD_NOP))
               return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_byte(logic [7:0] value, logic first);
         bit [31:0]     i;
         bit [63:0]     addr;
         bit            saturated;
         candidate_type hit;
         bytes_seen++;
         if (first) clear_scan();
         for (int k = 0; k < 7; k++) window[k] = window[k + 1];
         window[7] = value;
         saturated = (position == '1);
         if (!saturated && position >= 4 && position < length && length >= MIN_BUFFER &&
             found < limit) begin
            i = position - 32'd4;
            if (skip != 0) begin
               skip--;
            end else if (opens_function(i)) begin
               addr = base + 64'(i);
               skip = 4'(SKIP_COUNT);
               // a wrapped address is dropped but still skips ahead
               if (addr >= base) begin
                  found++;
                  hit.address = addr;
                  hit.number  = found;
                  awaited_candidates = {awaited_candidates, hit};
               end
            end
         end
         if (!saturated) position++;
      endfunction

      function void check_candidate(logic [79:0] data);
         candidate_type want;
         if (awaited_candidates.size() == 0) begin
            report($sformatf("unexpected candidate: expected none, got address %h number %0d",
                             data[63:0], data[79:64]));
            return;
         end
         want = awaited_candidates[0];
         awaited_candidates.delete(0);
         checked++;
         if (data[63:0] !== want.address)
            report($sformatf("candidate address: expected %h, got %h",
                             want.address, data[63:0]));
         if (data[79:64] !== want.number)
            report($sformatf("candidate number: expected %0d, got %0d",
                             want.number, data[79:64]));
      endfunction
   endclass
endpackage

module tb;
   import xpbs_pkg::*;
   import prologue_check_pkg::*;

   localparam int ITEM_TARGET = 1950;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 4;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] code_byte
   logic [0:0]  req_tuser;    // [0] buffer_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;    // [63:0] candidate_address, [79:64] candidate_number
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   prologue_tracker board;
   int          cycle_count = 0;
   int          burst_left  = 0;
   bit          sender_gaps = 1'b0;
   int          stall_style = 0;
   int          stall_tick  = 0;

   x86_prologue_byte_scanner_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: stall pattern chosen per phase.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ((stall_tick % 5) < 2);
         default: rsp_tready <= ($urandom_range(0, 9) > 6);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_candidate(rsp_tdata);
         if (req_tvalid && req_tready) board.note_byte(req_tdata, req_tuser[0]);
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(8 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] value, input logic first);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (sender_gaps) gap = $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold the sender until every predicted candidate has been seen.
   task automatic drain_scanner();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.awaited_candidates.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic append_prologue(input bit wide, ref logic [7:0] q[$]);
      int          start;
      logic [7:0]  frame;
      start = q.size();
      frame = $urandom_range(0, 1) ? 8'($urandom_range(0, 16)) : 8'($urandom);
      if (wide) begin
         case ($urandom_range(0, 8))
            0: begin
               q = {q, OPC_REX_W, OPC_MOV_STORE, MODRM_RBX_SIB, SIB_RSP};
            end
            1: begin
               q = {q, OPC_REX_W, OPC_GRP1_IMM8, MODRM_ESP, frame};
            end
            2: begin
               q = {q, OPC_REX_W, OPC_GRP1_IMM32, MODRM_ESP};
            end
            3: begin
               q = {q, OPC_PUSH_EBP, OPC_REX_W, OPC_MOV_RM, MODRM_ESP};
            end
            4: begin
               q = {q, OPC_REX_WR, OPC_MOV_STORE,
                    ($urandom_range(0, 1) ? MODRM_EAX_SIB : MODRM_ECX_SIB), SIB_RSP};
            end
            5: begin
               q = {q, PFX_REP, OPC_ESCAPE, OPC_ENDBR, ENDBR64_TAIL};
            end
            6: begin
               q = {q, OPC_REX, 8'($urandom_range(OPC_PUSH_FIRST - 2, OPC_PUSH_LAST + 2)),
                    OPC_REX_W, OPC_GRP1_IMM8, MODRM_ESP};
            end
            7: begin
               q = {q, 8'($urandom_range(OPC_PUSH_FIRST + 2, OPC_PUSH_LAST + 1)),
                    OPC_REX_W, OPC_GRP1_IMM8, MODRM_ESP};
            end
            default: begin
               q = {q, OPC_REX_W, OPC_MOV_RM, MODRM_RAX_RSP};
            end
         endcase
      end else begin
         case ($urandom_range(0, 4))
            0: begin
               q = {q, OPC_PUSH_EBP, OPC_MOV_RM, MODRM_ESP};
            end
            1: begin
               q = {q, OPC_GRP1_IMM8, MODRM_ESP, frame};
            end
            2: begin
               q = {q, OPC_GRP1_IMM32, MODRM_ESP};
            end
            3: begin
               q = {q, PFX_REP, OPC_ESCAPE, OPC_ENDBR, ENDBR32_TAIL};
            end
            default: begin
               q = {q, OPC_MOV_RM, MODRM_EDI_EDI, OPC_PUSH_EBP, OPC_MOV_RM, MODRM_ESP};
            end
         endcase
      end
      // near miss: flip one bit of the planted pattern
      if ($urandom_range(0, 4) == 0)
         q[$urandom_range(start, q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
   endtask

   initial begin
      logic [7:0]  code [$];
      logic [7:0]  directed [$];
      logic [63:0] base;
      logic [31:0] length;
      logic [15:0] limit;
      bit          mode;
      bit          opening;
      bit          mid_pause_done;
      int          n;
      int          phases;
      int          buffers;

      board          = new();
      mid_pause_done = 1'b0;
      phases         = 0;
      buffers        = 0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed buffer: endbr64 at offset zero without a start flag, a skipped
      // prologue, a padding-end hit, and both extreme byte values.
      stall_style = 1;
      csr_write(REG_MODE, 64'd1);
      csr_write(REG_BASE, 64'h0000_7FF6_0000_1000);
      csr_write(REG_LENGTH, 64'd24);
      csr_write(REG_LIMIT, 64'hFFFF);
      directed = '{PFX_REP, OPC_ESCAPE, OPC_ENDBR, ENDBR64_TAIL, PAD_ZERO, 8'hFF, 8'h80,
                   8'h7F, 8'h01, PAD_INT3, PAD_INT3, 8'hAA, OPC_REX_W, OPC_MOV_STORE,
                   MODRM_RBX_SIB, SIB_RSP, PAD_INT3, OPC_RET, 8'h31, PAD_NOP, OPC_RET,
                   PAD_NOP, PAD_ZERO, 8'hFF};
      foreach (directed[k]) send_byte(directed[k], 1'b0);
      buffers++;
      drain_scanner();

      while (board.bytes_seen < ITEM_TARGET) begin
         phases++;
         mode = $urandom_range(0, 1);
         case ($urandom_range(0, 4))
            0:       base = '0;
            1:       base = '1;
            2:       base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 64));
            default: base = {$urandom, $urandom};
         endcase
         case ($urandom_range(0, 9))
            0:       length = $urandom_range(0, 15);
            1:       length = 32'd16;
            2:       length = '1;
            3:       length = $urandom_range(100, 160);
            default: length = $urandom_range(17, 64);
         endcase
         case ($urandom_range(0, 5))
            0:       limit = '0;
            1:       limit = $urandom_range(1, 3);
            2:       limit = '1;
            3:       limit = LIMIT_RESET;
            default: limit = $urandom_range(4, 20);
         endcase
         // make sure the extremes come up early
         if (phases == 1) begin
            mode = 1'b0; base = '1; length = '0; limit = '0;
         end else if (phases == 2) begin
            mode = 1'b1; base = '0; length = '1; limit = '1;
         end
         csr_write(REG_MODE, 64'(mode));
         csr_write(REG_BASE, base);
         csr_write(REG_LENGTH, 64'(length));
         csr_write(REG_LIMIT, 64'(limit));
         stall_style = $urandom_range(0, 3);
         sender_gaps = ($urandom_range(0, 3) != 0);

         repeat ($urandom_range(1, 3)) begin
            if (length > 200)
               n = $urandom_range(30, 60);
            else if (length < 16)
               n = $urandom_range(length + 1, length + 20);
            else
               case ($urandom_range(0, 6))
                  0:       n = length + $urandom_range(1, 8);
                  1:       n = $urandom_range(1, length);
                  default: n = length;
               endcase
            code.delete();
            while (code.size() < n) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: append_prologue(($urandom_range(0, 5) == 0) ? !mode : mode, code);
                  4, 5: begin
                     case ($urandom_range(0, 3))
                        0: code = {code, PAD_INT3, PAD_INT3};
                        1: code = {code, PAD_INT3, OPC_RET};
                        2: code = {code, PAD_NOP, OPC_RET};
                        default: code = {code, PAD_NOP, PAD_NOP};
                     endcase
                     case ($urandom_range(0, 3))
                        0:       code = {code, PAD_INT3};
                        1:       code = {code, PAD_NOP};
                        2:       code = {code, PAD_ZERO};
                        default: code = {code, 8'($urandom)};
                     endcase
                  end
                  default: repeat ($urandom_range(1, 4)) code = {code, 8'($urandom)};
               endcase
            end
            while (code.size() > n) void'(code.pop_back());
            opening = ($urandom_range(0, 7) != 0);
            foreach (code[k]) begin
               if (!mid_pause_done && n > 20 && k == n / 2) begin
                  drain_scanner();
                  mid_pause_done = 1'b1;
               end
               send_byte(code[k], (k == 0) ? opening : ($urandom_range(0, 150) == 0));
            end
            buffers++;
         end
         drain_scanner();
      end

      repeat (8) @(posedge clock);
      $display("Scanned %0d code bytes in %0d buffers over %0d register settings,",
               board.bytes_seen, buffers, phases + 1);
      $display("with %0d candidate addresses checked against the prediction.", board.checked);
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
